// ===== hw/rtl/edfts_pkg.sv =====
// ----------------------------------------------------------------------------
// EDF task table scheduler package
// Shared types and constants: request codes, slot states and the layout of
// one task table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package edfts_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int TIME_W        = 32;

  typedef enum logic [3:0] {
    REQ_CREATE  = 4'd0,
    REQ_SETDL   = 4'd1,
    REQ_YIELD   = 4'd2,
    REQ_SLEEP   = 4'd3,
    REQ_PERIOD  = 4'd4,
    REQ_EXIT    = 4'd5,
    REQ_SWITCH  = 4'd6,
    REQ_START   = 4'd7,
    REQ_INFO    = 4'd8
  } req_code_t;

  typedef enum logic [1:0] {
    ST_DORMANT  = 2'd0,
    ST_READY    = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_SLEEPING = 2'd3
  } slot_state_t;

  typedef struct packed {
    logic              used;
    slot_state_t       state;
    logic [TIME_W-1:0] sleep;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] remaining;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // Value of an entry that has not been written since reset.
  localparam slot_entry_t ENTRY_RESET = '{
    used:      1'b0,
    state:     ST_DORMANT,
    sleep:     '1,
    deadline:  '1,
    remaining: '1
  };

endpackage

`default_nettype wire

// ===== hw/rtl/edf_task_table_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// EDF task table scheduler core
// Earliest-deadline-first scheduler over a table of task slots held in RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   -------   ------------------   ----------------------------------------
//   request   in_valid / in_stall  req_type, task_id, time_value,
//                                  task_valid, mem_ok
//   result    out_valid/out_stall  status, result_task, preempt_request,
//                                  slot_state_out, deadline_out, remaining_out
//
// Every item takes two table reads (the running slot, then the target slot)
// and then a result step before the result is loaded.
// Create, switch and start also sweep the whole table through the single RAM
// read port, one slot per cycle.
// The next item can be accepted in the cycle after the result is loaded.
// Reset is synchronous; per-slot valid bits make the table read as all
// dormant right after reset, with no clearing pass.
// A result that waits on out_stall sits in the output register while the
// next item is already accepted and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_task_table_scheduler_core #(
  parameter int NUM_SLOTS = edfts_pkg::NUM_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  req_type,
  input  wire logic [3:0]  task_id,
  input  wire logic signed [31:0] time_value,
  input  wire logic        task_valid,
  input  wire logic        mem_ok,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             status,
  output logic [3:0]       result_task,
  output logic             preempt_request,
  output logic [1:0]       slot_state_out,
  output logic signed [31:0] deadline_out,
  output logic signed [31:0] remaining_out
);

  import edfts_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_TGT,
    S_SCAN,
    S_FIN,
    S_DONE
  } state_t;

  state_t state;

  // Latched request.
  req_code_t         req_q;
  logic [3:0]        tid_q;
  logic [TIME_W-1:0] tv_q;
  logic              tvalid_q;
  logic              memok_q;

  // Scheduler state outside the table.
  logic [SLOT_W-1:0] run_slot;
  logic [CNT_W-1:0]  task_count;

  slot_entry_t       run_word;

  // Table sweep.
  logic [SLOT_W-1:0] scan_idx;
  logic              iss_done;
  logic              arr_vld;
  logic [SLOT_W-1:0] arr_pos;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              best_found;
  logic [SLOT_W-1:0] best_idx;
  slot_entry_t       best_word;
  slot_entry_t       word0;

  // Finished result waiting for the output register.
  logic              res_status;
  logic [SLOT_W-1:0] res_task;
  logic              res_preempt;
  logic [1:0]        res_st;
  logic [TIME_W-1:0] res_dl;
  logic [TIME_W-1:0] res_rem;

  // Table port.
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_entry_t       wr_data;
  logic [SLOT_W-1:0] rd_addr;
  slot_entry_t       rd_data;

  // Decisions of the current cycle.
  logic              done_now;
  logic              go_scan;
  logic              cnt_inc;
  logic              cnt_dec;
  logic              set_run;
  logic [SLOT_W-1:0] chosen;
  logic              fin_status;
  logic [SLOT_W-1:0] fin_task;
  logic              fin_preempt;
  logic [1:0]        fin_st;
  logic [TIME_W-1:0] fin_dl;
  logic [TIME_W-1:0] fin_rem;
  logic              out_load;

  logic              run_is_idle;
  logic              tv_pos;
  logic              tid_in_range;
  logic [SLOT_W-1:0] tid_slot;
  logic              scan_better;

  edfts_table #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign run_is_idle  = (run_slot == '0);
  assign tv_pos       = !tv_q[TIME_W-1] && (tv_q != '0);
  assign tid_in_range = (32'(tid_q) < NUM_SLOTS);
  assign tid_slot     = SLOT_W'(tid_q);

  // A ready slot beats the best so far only on a strictly smaller signed
  // remaining time, so ties stay with the lower slot.
  assign scan_better = (rd_data.state == ST_READY) &&
                       (!best_found ||
                        ($signed(rd_data.remaining) < $signed(best_word.remaining)));

  assign in_stall = (state != S_IDLE);

  // The finished result moves to the output register once it is free or
  // being taken in this cycle.
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    rd_addr     = run_slot;
    wr_en       = 1'b0;
    wr_addr     = run_slot;
    wr_data     = run_word;
    done_now    = 1'b0;
    go_scan     = 1'b0;
    cnt_inc     = 1'b0;
    cnt_dec     = 1'b0;
    set_run     = 1'b0;
    chosen      = best_found ? best_idx : '0;
    fin_status  = 1'b0;
    fin_task    = '0;
    fin_preempt = 1'b0;
    fin_st      = '0;
    fin_dl      = '0;
    fin_rem     = '0;

    unique case (state)
      S_IDLE: begin
        rd_addr = run_slot;
      end

      // Running slot data arrives now; fetch the target slot next.
      S_RUN: begin
        rd_addr = (req_q == REQ_START) ? SLOT_W'(1) : tid_slot;
      end

      // run_word holds the running slot, rd_data the target slot.
      S_TGT: begin
        unique case (req_q)
          REQ_CREATE: begin
            if ((task_count < CNT_W'(NUM_SLOTS)) && tv_pos && tvalid_q) begin
              go_scan = 1'b1;
            end else begin
              done_now   = 1'b1;
              fin_status = 1'b1;
            end
          end
          REQ_SETDL: begin
            done_now = 1'b1;
            if (!tv_pos || (tid_q == '0) || !tid_in_range || !rd_data.used ||
                (tid_slot == run_slot)) begin
              fin_status = 1'b1;
            end else begin
              wr_en             = 1'b1;
              wr_addr           = tid_slot;
              wr_data           = rd_data;
              wr_data.deadline  = tv_q;
              wr_data.remaining = tv_q;
              fin_preempt       = !run_is_idle && (tv_q < run_word.remaining);
            end
          end
          REQ_YIELD: begin
            done_now = 1'b1;
            if (run_is_idle) begin
              fin_status = 1'b1;
            end else begin
              wr_en             = 1'b1;
              wr_data.remaining = run_word.deadline;
              fin_preempt       = 1'b1;
            end
          end
          REQ_SLEEP: begin
            done_now = 1'b1;
            if (tv_pos) begin
              wr_en         = 1'b1;
              wr_data.state = ST_SLEEPING;
              wr_data.sleep = tv_q;
              fin_preempt   = !run_is_idle;
            end
          end
          REQ_PERIOD: begin
            done_now      = 1'b1;
            wr_en         = 1'b1;
            wr_data.state = ST_SLEEPING;
            wr_data.sleep = run_word.remaining;
            fin_preempt   = !run_is_idle;
          end
          REQ_EXIT: begin
            done_now = 1'b1;
            if (run_is_idle || !memok_q) begin
              fin_status = 1'b1;
            end else begin
              wr_en         = 1'b1;
              wr_data.state = ST_DORMANT;
              wr_data.used  = 1'b0;
              cnt_dec       = 1'b1;
              fin_preempt   = 1'b1;
            end
          end
          REQ_SWITCH: begin
            // Demote the running task first; the sweep starts in the next cycle
            // and so sees the new state.
            go_scan = 1'b1;
            if (run_word.state == ST_RUNNING) begin
              wr_en         = 1'b1;
              wr_data.state = ST_READY;
            end
          end
          REQ_START: begin
            if (rd_data.state == ST_DORMANT) begin
              done_now   = 1'b1;
              fin_status = 1'b1;
            end else begin
              go_scan = 1'b1;
            end
          end
          REQ_INFO: begin
            done_now = 1'b1;
            if ((task_count <= CNT_W'(1)) || (tid_q == '0) || !tid_in_range ||
                !rd_data.used) begin
              fin_status = 1'b1;
            end else begin
              fin_st  = rd_data.state;
              fin_dl  = rd_data.deadline;
              fin_rem = rd_data.remaining;
            end
          end
          default: begin
            done_now   = 1'b1;
            fin_status = 1'b1;
          end
        endcase
      end

      S_SCAN: begin
        rd_addr = scan_idx;
      end

      S_FIN: begin
        done_now = 1'b1;
        if (req_q == REQ_CREATE) begin
          if (!free_found || !memok_q) begin
            fin_status = 1'b1;
          end else begin
            wr_en             = 1'b1;
            wr_addr           = free_idx;
            wr_data.used      = 1'b1;
            wr_data.state     = ST_READY;
            wr_data.sleep     = '1;
            wr_data.deadline  = tv_q;
            wr_data.remaining = tv_q;
            cnt_inc           = 1'b1;
            fin_task          = free_idx;
            // A new task in the slot the running one left never asks for preemption.
            fin_preempt       = !run_is_idle && (free_idx != run_slot) &&
                                (tv_q < run_word.remaining);
          end
        end else begin
          wr_en         = 1'b1;
          wr_addr       = chosen;
          wr_data       = best_found ? best_word : word0;
          wr_data.state = ST_RUNNING;
          set_run       = 1'b1;
          fin_task      = chosen;
        end
      end

      S_DONE: begin
        rd_addr = run_slot;
      end

      default: begin
        rd_addr = run_slot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      run_slot   <= '0;
      task_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cnt_inc) begin
        task_count <= task_count + CNT_W'(1);
      end else if (cnt_dec && (task_count != '0)) begin
        task_count <= task_count - CNT_W'(1);
      end

      if (set_run) begin
        run_slot <= chosen;
      end

      if (done_now) begin
        res_status  <= fin_status;
        res_task    <= fin_task;
        res_preempt <= fin_preempt;
        res_st      <= fin_st;
        res_dl      <= fin_dl;
        res_rem     <= fin_rem;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_q    <= req_code_t'(req_type);
            tid_q    <= task_id;
            tv_q     <= time_value;
            tvalid_q <= task_valid;
            memok_q  <= mem_ok;
            state    <= S_RUN;
          end
        end

        S_RUN: begin
          run_word <= rd_data;
          state    <= S_TGT;
        end

        S_TGT: begin
          if (go_scan) begin
            scan_idx   <= '0;
            iss_done   <= 1'b0;
            arr_vld    <= 1'b0;
            free_found <= 1'b0;
            best_found <= 1'b0;
            state      <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end

        S_SCAN: begin
          if (!iss_done) begin
            arr_vld <= 1'b1;
            arr_pos <= scan_idx;
            if (scan_idx == LAST_SLOT) begin
              iss_done <= 1'b1;
            end else begin
              scan_idx <= scan_idx + SLOT_W'(1);
            end
          end else begin
            arr_vld <= 1'b0;
          end

          if (arr_vld) begin
            if (arr_pos == '0) begin
              // The idle slot is never a candidate but is the fallback pick.
              word0 <= rd_data;
            end else if (req_q == REQ_CREATE) begin
              if (!free_found && !rd_data.used) begin
                free_found <= 1'b1;
                free_idx   <= arr_pos;
              end
            end else if (scan_better) begin
              best_found <= 1'b1;
              best_idx   <= arr_pos;
              best_word  <= rd_data;
            end
            if (arr_pos == LAST_SLOT) begin
              state <= S_FIN;
            end
          end
        end

        S_FIN: begin
          state <= S_DONE;
        end

        S_DONE: begin
          if (out_load) begin
            status          <= res_status;
            result_task     <= 4'(res_task);
            preempt_request <= res_preempt;
            slot_state_out  <= res_st;
            deadline_out    <= res_dl;
            remaining_out   <= res_rem;
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/edfts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module edfts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/edfts_table.sv =====
// ----------------------------------------------------------------------------
// EDF task table
// Task slot storage in one RAM. A valid bit per slot makes entries that were
// not written since reset read as the reset entry, so no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module edfts_table #(
  parameter int NUM_SLOTS = edfts_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
  input  wire edfts_pkg::slot_entry_t       wr_data,
  input  wire logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
  output edfts_pkg::slot_entry_t            rd_data
);

  import edfts_pkg::*;

  logic [NUM_SLOTS-1:0] valid;
  logic                 rd_valid;
  logic [ENTRY_W-1:0]   ram_q;

  edfts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // The valid bit is sampled with the read so both refer to the same address.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid ? slot_entry_t'(ram_q) : ENTRY_RESET;

endmodule

`default_nettype wire

// ===== hw/rtl/edfts_checker.sv =====
// ----------------------------------------------------------------------------
// EDF task table scheduler checker
// Port-level assertions on the scheduler core, attached by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module edfts_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [3:0]  req_type,
  input wire logic [3:0]  task_id,
  input wire logic [31:0] time_value,
  input wire logic        task_valid,
  input wire logic        mem_ok,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        status,
  input wire logic [3:0]  result_task,
  input wire logic        preempt_request,
  input wire logic [1:0]  slot_state_out,
  input wire logic [31:0] deadline_out,
  input wire logic [31:0] remaining_out
);

  // A result held by the receiver keeps its valid and all of its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(result_task) && $stable(preempt_request) &&
      $stable(slot_state_out) && $stable(deadline_out) && $stable(remaining_out))
    else $error("stalled result changed");

  // An error result carries nothing else.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (result_task == 4'd0) && !preempt_request &&
      (slot_state_out == 2'd0) && (deadline_out == 32'd0) &&
      (remaining_out == 32'd0))
    else $error("error result has nonzero fields");

  // Requests are handled one at a time: the block is busy after accepting.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while the previous one is in work");

  // No result can appear in the cycle right after a request is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind edf_task_table_scheduler_core edfts_checker u_edfts_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// EDF task table scheduler testbench
// Drives scheduler requests through the valid/stall request channel, predicts
// each reply from a behavioral copy of the task table unless a directed row
// gives it by hand, and checks each reply field by field. A short directed
// table comes first, then random traffic built from short request sequences.
// The sender idles in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------

module tb;
  import edfts_pkg::*;

  localparam int NSLOT       = edfts_pkg::NUM_SLOTS_DEF;
  localparam int RANDOM_REQS = 1650;
  localparam int DRAIN_EVERY = 400;
  localparam int SETTLE_CYC  = 48;
  localparam int CYCLE_LIMIT = 400000;

  // Request codes above REQ_INFO are not defined and must be refused.
  localparam logic [3:0] REQ_UNDEFINED = 4'hF;

  // Marks a directed row whose reply is written into the table by hand.
  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    logic [3:0]  req;
    logic [3:0]  tid;
    logic [31:0] tv;
    logic        tvalid;
    logic        memok;
  } sched_req_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  task_no;
    logic        preempt;
    slot_state_t state;
    logic [31:0] deadline;
    logic [31:0] remaining;
  } sched_result_t;

  typedef struct packed {
    sched_req_t    rq;
    logic          typed;
    sched_result_t want;
  } dir_row_t;

  // The receiver switches between these stall behaviors from time to time.
  typedef enum logic [1:0] {
    RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC
  } rx_mode_t;

  logic                clk;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [3:0]          req_type    = '0;
  logic [3:0]          task_id     = '0;
  logic signed [31:0]  time_value  = '0;
  logic                task_valid  = 1'b0;
  logic                mem_ok      = 1'b0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic                status;
  logic [3:0]          result_task;
  logic                preempt_request;
  logic [1:0]          slot_state_out;
  logic signed [31:0]  deadline_out;
  logic signed [31:0]  remaining_out;

  // Travels with each request item: a typed reply overrides the prediction.
  logic                row_typed  = 1'b0;
  sched_result_t       row_expect = '0;

  // Behavioral copy of the task table.
  slot_state_t         tbl_state     [NSLOT];
  logic                tbl_used      [NSLOT];
  logic [31:0]         tbl_deadline  [NSLOT];
  logic [31:0]         tbl_remaining [NSLOT];
  logic [31:0]         tbl_sleep     [NSLOT];
  logic [3:0]          cur_running;
  int                  live_count;

  sched_result_t       sched_replies_due [$];
  sched_result_t       predicted;
  sched_result_t       due;
  dir_row_t            dir_tab [$];
  int                  mismatch_count = 0;
  int unsigned         cycle_count    = 0;
  int                  burst_left     = 0;
  rx_mode_t            rx_mode        = RX_FREE;
  int                  rx_phase_left  = 0;

  edf_task_table_scheduler_core #(.NUM_SLOTS(NSLOT)) DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .task_id         (task_id),
    .time_value      (time_value),
    .task_valid      (task_valid),
    .mem_ok          (mem_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .result_task     (result_task),
    .preempt_request (preempt_request),
    .slot_state_out  (slot_state_out),
    .deadline_out    (deadline_out),
    .remaining_out   (remaining_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Reply prediction
  // ------------------------------------------------------------------------

  // Deadlines and sleep times must be strictly positive as signed values.
  function automatic logic not_positive(logic [31:0] v);
    return (v == '0) || v[31];
  endfunction

  // Ready slot with the least signed remaining time; the lowest slot wins a
  // tie. The idle slot is chosen when nothing is ready.
  function automatic logic [3:0] earliest_ready_slot();
    logic [3:0] best;
    logic       found;
    best  = '0;
    found = 1'b0;
    for (int i = 1; i < NSLOT; i++) begin
      if (tbl_state[i] == ST_READY &&
          (!found || $signed(tbl_remaining[i]) < $signed(tbl_remaining[best]))) begin
        best  = 4'(i);
        found = 1'b1;
      end
    end
    return best;
  endfunction

  // Applies one request to the table copy and returns the reply it causes.
  // Any refused request answers with status set and every other field zero.
  function automatic sched_result_t predict_sched_reply(sched_req_t rq);
    sched_result_t r;
    logic [3:0]    run;
    logic [3:0]    slot;
    r   = '0;
    run = cur_running;
    case (rq.req)
      REQ_CREATE: begin
        slot = '0;
        if (live_count < NSLOT && !not_positive(rq.tv) && rq.tvalid) begin
          for (int i = NSLOT - 1; i >= 1; i--)
            if (!tbl_used[i]) slot = 4'(i);
        end
        if (slot == '0 || !rq.memok) begin
          r.status = 1'b1;
        end else begin
          tbl_used[slot]      = 1'b1;
          tbl_state[slot]     = ST_READY;
          tbl_deadline[slot]  = rq.tv;
          tbl_remaining[slot] = rq.tv;
          tbl_sleep[slot]     = '1;
          live_count++;
          r.task_no = slot;
          // The new slot may be the exited one that is still marked running,
          // so the comparison uses the table after the write.
          r.preempt = (run != '0) && (rq.tv < tbl_remaining[run]);
        end
      end
      REQ_SETDL: begin
        if (not_positive(rq.tv) || rq.tid == '0 || !tbl_used[rq.tid] || rq.tid == run) begin
          r.status = 1'b1;
        end else begin
          tbl_deadline[rq.tid]  = rq.tv;
          tbl_remaining[rq.tid] = rq.tv;
          r.preempt = (run != '0) && (rq.tv < tbl_remaining[run]);
        end
      end
      REQ_YIELD: begin
        if (run == '0) begin
          r.status = 1'b1;
        end else begin
          tbl_remaining[run] = tbl_deadline[run];
          r.preempt = 1'b1;
        end
      end
      REQ_SLEEP: begin
        if (!not_positive(rq.tv)) begin
          tbl_state[run] = ST_SLEEPING;
          tbl_sleep[run] = rq.tv;
          r.preempt = (run != '0);
        end
      end
      REQ_PERIOD: begin
        tbl_state[run] = ST_SLEEPING;
        tbl_sleep[run] = tbl_remaining[run];
        r.preempt = (run != '0);
      end
      REQ_EXIT: begin
        if (run == '0 || !rq.memok) begin
          r.status = 1'b1;
        end else begin
          tbl_state[run] = ST_DORMANT;
          tbl_used[run]  = 1'b0;
          if (live_count > 0) live_count--;
          r.preempt = 1'b1;
        end
      end
      REQ_SWITCH: begin
        if (tbl_state[run] == ST_RUNNING) tbl_state[run] = ST_READY;
        slot = earliest_ready_slot();
        cur_running     = slot;
        tbl_state[slot] = ST_RUNNING;
        r.task_no       = slot;
      end
      REQ_START: begin
        if (tbl_state[1] == ST_DORMANT) begin
          r.status = 1'b1;
        end else begin
          slot = earliest_ready_slot();
          cur_running     = slot;
          tbl_state[slot] = ST_RUNNING;
          r.task_no       = slot;
        end
      end
      REQ_INFO: begin
        if (live_count <= 1 || rq.tid == '0 || !tbl_used[rq.tid]) begin
          r.status = 1'b1;
        end else begin
          r.state     = tbl_state[rq.tid];
          r.deadline  = tbl_deadline[rq.tid];
          r.remaining = tbl_remaining[rq.tid];
        end
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Monitors
  // ------------------------------------------------------------------------

  // Every accepted request item queues the reply it must produce. Inputs are
  // driven by nonblocking writes at the edge, so the values read here are
  // the ones the block sampled.
  always @(posedge clk) begin
    if (!rst && in_valid && in_stall === 1'b0) begin
      predicted = predict_sched_reply(sched_req_t'{req: req_type, tid: task_id,
                                                   tv: time_value, tvalid: task_valid,
                                                   memok: mem_ok});
      if (row_typed) predicted = row_expect;
      sched_replies_due.push_back(predicted);
    end
  end

  task automatic cmp_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Each accepted reply item is checked against the oldest pending reply.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (sched_replies_due.size() == 0) begin
        $display("%0t ns: reply with none pending, expected nothing, actual status %0h task %0h",
                 $time, status, result_task);
        mismatch_count++;
      end else begin
        due = sched_replies_due.pop_front();
        cmp_field("status", due.status, status);
        cmp_field("result_task", due.task_no, result_task);
        cmp_field("preempt_request", due.preempt, preempt_request);
        cmp_field("slot_state_out", due.state, slot_state_out);
        cmp_field("deadline_out", due.deadline, deadline_out);
        cmp_field("remaining_out", due.remaining, remaining_out);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Receiver: stretches of free flow, light and heavy random stalls, and a
  // regular on/off pattern, each held for a random number of cycles.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       <= rx_mode_t'($urandom_range(0, 3));
      rx_phase_left <= $urandom_range(16, 96);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= cycle_count[2];
    endcase
  end

  // ------------------------------------------------------------------------
  // Sender
  // ------------------------------------------------------------------------

  // Presents one request item and returns at the edge that accepts it. Items
  // go out in bursts of random length; between bursts valid drops for a
  // random gap, and a zero gap lets bursts run together.
  task automatic issue_req(sched_req_t rq, logic typed = PREDICTED,
                           sched_result_t want = '0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid   <= 1'b1;
    req_type   <= rq.req;
    task_id    <= rq.tid;
    time_value <= rq.tv;
    task_valid <= rq.tvalid;
    mem_ok     <= rq.memok;
    row_typed  <= typed;
    row_expect <= want;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    burst_left--;
  endtask

  // Drops valid and waits until every pending reply has been checked.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sched_replies_due.size() != 0);
    burst_left = 0;
  endtask

  // Mostly positive deadlines, many of them small so that ties come up,
  // with the extremes and some refused values mixed in.
  function automatic logic [31:0] pick_deadline();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return $urandom_range(1, 48);
    if (roll < 80) return $urandom_range(1, 32'h7FFF_FFFF);
    if (roll < 88) return roll[0] ? 32'h7FFF_FFFF : 32'd1;
    if (roll < 94) return $urandom | 32'h8000_0000;
    if (roll < 97) return 32'h8000_0000;
    return 32'd0;
  endfunction

  // Usually an occupied slot, otherwise any slot at all.
  function automatic logic [3:0] pick_target();
    logic [3:0] id;
    if ($urandom_range(0, 3) != 0) begin
      for (int k = 0; k < 8; k++) begin
        id = 4'($urandom_range(1, NSLOT - 1));
        if (tbl_used[id]) return id;
      end
    end
    return 4'($urandom_range(0, NSLOT - 1));
  endfunction

  function automatic logic mostly_one();
    return $urandom_range(0, 9) != 0;
  endfunction

  // Random traffic made of short, mostly well-formed sequences. Sleeping
  // tasks never wake inside the block, so a sleep is usually followed by an
  // exit of the same task; otherwise the table would fill with tasks that
  // can never run again. Now and then the table is filled to the top.
  task automatic run_random(int n_items);
    int         sent;
    int         roll;
    int         busy;
    int         drain_mark;
    sched_req_t rq;
    sent       = 0;
    drain_mark = DRAIN_EVERY;
    while (sent < n_items) begin
      busy = 0;
      for (int i = 1; i < NSLOT; i++) busy += tbl_used[i];
      roll      = $urandom_range(0, 99);
      rq.req    = REQ_CREATE;
      rq.tid    = pick_target();
      rq.tv     = pick_deadline();
      rq.tvalid = mostly_one();
      rq.memok  = mostly_one();
      if (roll < 2) begin
        // Filling burst: more creates than there are free slots.
        repeat (NSLOT) begin
          rq.tv     = pick_deadline();
          rq.tvalid = 1'b1;
          rq.memok  = 1'b1;
          issue_req(rq);
          sent++;
        end
      end else if ((busy < 3 && roll < 60) || roll < 20) begin
        issue_req(rq);
        sent++;
      end else if (roll < 28) begin
        rq.req = REQ_SETDL;
        issue_req(rq);
        sent++;
      end else if (roll < 35) begin
        rq.req = REQ_YIELD;
        issue_req(rq);
        sent++;
      end else if (roll < 44) begin
        rq.req = (roll < 40) ? REQ_SLEEP : REQ_PERIOD;
        issue_req(rq);
        sent++;
        if ($urandom_range(0, 19) != 0) begin
          rq.req   = REQ_EXIT;
          rq.memok = 1'b1;
          issue_req(rq);
          sent++;
        end
      end else if (roll < 54) begin
        // Put a ready task on the processor, then let it exit.
        rq.req = REQ_SWITCH;
        issue_req(rq);
        rq.req = REQ_EXIT;
        issue_req(rq);
        sent += 2;
      end else if (roll < 70) begin
        rq.req = REQ_SWITCH;
        issue_req(rq);
        sent++;
      end else if (roll < 76) begin
        rq.req = REQ_START;
        issue_req(rq);
        sent++;
      end else if (roll < 92) begin
        rq.req = REQ_INFO;
        issue_req(rq);
        sent++;
      end else begin
        // Noise: any code, undefined ones included, with raw field values.
        rq.req    = 4'($urandom_range(0, 15));
        rq.tid    = 4'($urandom);
        rq.tv     = $urandom;
        rq.tvalid = 1'($urandom);
        rq.memok  = 1'($urandom);
        issue_req(rq);
        sent++;
      end
      // From time to time the sender waits for the block to empty out.
      if (sent >= drain_mark) begin
        hold_until_drained();
        drain_mark += DRAIN_EVERY;
      end
    end
  endtask

  function automatic dir_row_t drow(logic [3:0] rq, logic [3:0] id, logic [31:0] tv,
                                    int tval, int mok, logic typed, int e_err,
                                    int e_slot, int e_pre, slot_state_t e_st,
                                    logic [31:0] e_dl, logic [31:0] e_rem);
    dir_row_t d;
    d.rq    = '{req: rq, tid: id, tv: tv, tvalid: 1'(tval), memok: 1'(mok)};
    d.typed = typed;
    d.want  = '{status: 1'(e_err), task_no: 4'(e_slot), preempt: 1'(e_pre), state: e_st,
                deadline: e_dl, remaining: e_rem};
    return d;
  endfunction

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tbl_state[i]     = ST_DORMANT;
      tbl_used[i]      = 1'b0;
      tbl_deadline[i]  = '1;
      tbl_remaining[i] = '1;
      tbl_sleep[i]     = '1;
    end
    cur_running = '0;
    live_count  = 0;

    // Directed table. Columns: request, slot, time, task_valid, mem_ok, then
    // whether the reply is typed here, and the reply itself (error, slot,
    // preempt, state, deadline, remaining).
    // With nothing created, info, start, yield and exit are all refused, and
    // a switch falls back on the idle task.
    dir_tab.push_back(drow(REQ_INFO,   4'd1, 32'd0, 1, 1, TYPED, 1, 0, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_START,  4'd0, 32'd0, 1, 1, TYPED, 1, 0, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_YIELD,  4'd0, 32'd0, 1, 1, TYPED, 1, 0, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_EXIT,   4'd0, 32'd0, 1, 1, TYPED, 1, 0, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_SWITCH, 4'd0, 32'd0, 1, 1, TYPED, 0, 0, 0, ST_DORMANT, 0, 0));
    // Creates refused for a zero deadline, the most negative deadline, an
    // unusable descriptor and a failed stack allocation.
    dir_tab.push_back(drow(REQ_CREATE, 4'd0, 32'd0, 1, 1, TYPED, 1, 0, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_CREATE, 4'd0, 32'h8000_0000, 1, 1, TYPED,
                           1, 0, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_CREATE, 4'd0, 32'd5, 0, 1, TYPED, 1, 0, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_CREATE, 4'd0, 32'd5, 1, 0, TYPED, 1, 0, 0, ST_DORMANT, 0, 0));
    // Three tasks: the largest deadline, then two equal ones for a tie.
    dir_tab.push_back(drow(REQ_CREATE, 4'd0, 32'h7FFF_FFFF, 1, 1, TYPED,
                           0, 1, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_CREATE, 4'd15, 32'd100, 1, 1, TYPED, 0, 2, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_CREATE, 4'd15, 32'd100, 1, 1, TYPED, 0, 3, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_INFO,   4'd2, 32'd0, 1, 1, TYPED, 0, 0, 0, ST_READY, 100, 100));
    dir_tab.push_back(drow(REQ_INFO,   4'd15, 32'd0, 1, 1, TYPED, 1, 0, 0, ST_DORMANT, 0, 0));
    // Start breaks the tie toward the lower slot.
    dir_tab.push_back(drow(REQ_START,  4'd0, 32'd0, 1, 1, TYPED, 0, 2, 0, ST_DORMANT, 0, 0));
    // The running task cannot take a new deadline; another one can, and a
    // shorter one asks for preemption.
    dir_tab.push_back(drow(REQ_SETDL,  4'd2, 32'd7, 1, 1, TYPED, 1, 0, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_SETDL,  4'd3, 32'd50, 1, 1, TYPED, 0, 0, 1, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_SWITCH, 4'd0, 32'd0, 1, 1, TYPED, 0, 3, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_YIELD,  4'd0, 32'd0, 1, 1, PREDICTED, 0, 0, 0, ST_DORMANT, 0, 0));
    // A negative sleep time is ignored without an error.
    dir_tab.push_back(drow(REQ_SLEEP,  4'd0, 32'hFFFF_FFFB, 1, 1, TYPED,
                           0, 0, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_SLEEP,  4'd0, 32'h7FFF_FFFF, 1, 1, PREDICTED,
                           0, 0, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_EXIT,   4'd0, 32'd0, 1, 0, TYPED, 1, 0, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_EXIT,   4'd0, 32'd0, 1, 1, TYPED, 0, 0, 1, ST_DORMANT, 0, 0));
    // Period yield on the exited task, which still counts as running.
    dir_tab.push_back(drow(REQ_PERIOD, 4'd0, 32'd0, 1, 1, PREDICTED, 0, 0, 0, ST_DORMANT, 0, 0));
    dir_tab.push_back(drow(REQ_UNDEFINED, 4'd0, 32'hFFFF_FFFF, 0, 0, TYPED,
                           1, 0, 0, ST_DORMANT, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[k]) issue_req(dir_tab[k].rq, dir_tab[k].typed, dir_tab[k].want);
    hold_until_drained();

    run_random(RANDOM_REQS);

    // Let the last replies come out, then watch a little longer for any
    // reply that should not be there.
    hold_until_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_count == 0 && sched_replies_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
